// ===== hdl/planar_yuv_to_packed_decimating_packer_defines.svh =====
// Assertion macros shared by the packer RTL.
`ifndef PLANAR_YUV_TO_PACKED_DECIMATING_PACKER_DEFINES_SVH
`define PLANAR_YUV_TO_PACKED_DECIMATING_PACKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define YPK_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("assertion failed: condition must never hold");
`define YPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: expected condition one cycle later");
`else
`define YPK_ASSERT_NEVER(lbl, clk, rst_n, cond)
`define YPK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/ypk_pkg.sv =====
// Types and constants of the planar-to-packed decimating packer.
`default_nettype none
package ypk_pkg;

    localparam int DIM_W      = 12;
    localparam int ACC_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [DIM_W-1:0] DIM_RESET = 12'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH  = 3'd0,
        CFG_SRC_HEIGHT = 3'd1,
        CFG_DST_WIDTH  = 3'd2,
        CFG_DST_HEIGHT = 3'd3,
        CFG_RUN_WIDTH  = 3'd4,
        CFG_RUN_ROWS   = 3'd5,
        CFG_HSCALE_ON  = 3'd6,
        CFG_VSCALE_ON  = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] luma_left;
        logic [7:0] luma_right;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
    } t_in_item;

    typedef struct packed {
        logic [31:0] packed_word;
        logic        row_end;
    } t_out_item;

    // Kept macropixel waiting between classifier and packer
    typedef struct packed {
        t_in_item item;
        logic     row_end;
    } t_entry;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [LVL_W-1:0] level;
    } t_fifo_status;

endpackage
`default_nettype wire

// ===== hdl/planar_yuv_to_packed_decimating_packer.sv =====
// A kept macropixel is written into the queue on its transfer, then loaded into the result register when it is free.
// Throughput: one macropixel per cycle while the queue is not full; dropped macropixels produce no result.
// A four-entry queue between the classifier and the packer absorbs short output stalls.
// Configuration port is always ready; writes take effect on the next cycle.
// Synchronous reset restores default sizes, clears enables, frame state and the queue.
`default_nettype none
`include "planar_yuv_to_packed_decimating_packer_defines.svh"
module planar_yuv_to_packed_decimating_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  ypk_pkg::t_in_item             i_item,
    output logic                          o_empty,
    input  logic                          i_pop,
    output ypk_pkg::t_out_item            o_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ypk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ypk_pkg::DIM_W-1:0]     i_cfg_data
);
    import ypk_pkg::*;

    logic         w_accept;
    logic         w_keep;
    logic         w_fifo_push;
    logic         w_fifo_pop;
    t_entry       w_front_entry;
    t_entry       w_fifo_entry;
    t_fifo_status w_status;

    assign o_cfg_ready = 1'b1;
    assign o_full      = w_status.full;
    assign w_accept    = i_push && !w_status.full;
    assign w_fifo_push = w_accept && w_keep;

    ypk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_item      (i_item),
        .o_keep      (w_keep),
        .o_entry     (w_front_entry)
    );

    ypk_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_fifo_push),
        .i_entry  (w_front_entry),
        .i_pop    (w_fifo_pop),
        .o_entry  (w_fifo_entry),
        .o_status (w_status)
    );

    ypk_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .i_entry    (w_fifo_entry),
        .o_fifo_pop (w_fifo_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_item     (o_item)
    );

    `YPK_ASSERT_NEVER(a_level_bound, i_clk, i_rst_n, w_status.level > LVL_W'(FIFO_DEPTH))
    `YPK_ASSERT_NEXT(a_kept_visible, i_clk, i_rst_n, w_fifo_push, !w_status.empty || !o_empty)
    `YPK_ASSERT_NEXT(a_back_drains, i_clk, i_rst_n, o_empty && !w_status.empty, !o_empty)

endmodule
`default_nettype wire

// ===== hdl/ypk_fifo.sv =====
// Short queue of kept macropixels between the classifier and the packer.
`default_nettype none
module ypk_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  ypk_pkg::t_entry      i_entry,
    input  logic                 i_pop,
    output ypk_pkg::t_entry      o_entry,
    output ypk_pkg::t_fifo_status o_status
);
    import ypk_pkg::*;

    t_entry             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [LVL_W-1:0]   r_level;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_level <= r_level + 1'b1;
            end else if (i_pop && !i_push) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_entry        = r_mem[r_rd_ptr];
    assign o_status.empty = (r_level == '0);
    assign o_status.full  = (r_level == LVL_W'(FIFO_DEPTH));
    assign o_status.level = r_level;

endmodule
`default_nettype wire

// ===== hdl/ypk_front.sv =====
// Configuration registers and row/macropixel drop decisions.
`default_nettype none
module ypk_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [ypk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ypk_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  ypk_pkg::t_in_item             i_item,
    output logic                          o_keep,
    output ypk_pkg::t_entry               o_entry
);
    import ypk_pkg::*;

    logic [DIM_W-1:0] r_src_width, r_src_height, r_dst_width, r_dst_height;
    logic [DIM_W-1:0] r_run_width, r_run_rows;
    logic             r_hscale_on, r_vscale_on;

    logic [DIM_W-1:0]   r_row_count, n_row_count;
    logic [DIM_W-2:0]   r_col_count, n_col_count;
    logic [ACC_W-1:0]   r_row_accum, n_row_accum;
    logic [ACC_W-1:0]   r_row_mark, n_row_mark;
    logic [ACC_W-1:0]   r_col_accum, n_col_accum;
    logic [ACC_W-1:0]   r_col_mark, n_col_mark;
    logic               r_row_dropping, n_row_dropping;

    logic [DIM_W-1:0]   w_hdiff, w_wdiff, w_rows_per_frame;
    logic [DIM_W:0]     w_wdiff2, w_src_width2;
    logic [DIM_W-2:0]   w_items_per_row;
    logic [DIM_W-1:0]   w_col_inc;
    logic [DIM_W:0]     w_row_inc;
    logic               w_last, w_row_wrap, w_first_col, w_frame_first;
    logic [ACC_W-1:0]   w_ra, w_rm, w_ca, w_cm;
    logic [ACC_W:0]     w_rm_lim, w_cm_lim;
    logic               w_row_drop, w_rd, w_drop_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= DIM_RESET;
            r_src_height <= DIM_RESET;
            r_dst_width  <= DIM_RESET;
            r_dst_height <= DIM_RESET;
            r_run_width  <= DIM_RESET;
            r_run_rows   <= DIM_RESET;
            r_hscale_on  <= 1'b0;
            r_vscale_on  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                CFG_RUN_WIDTH:  r_run_width  <= i_cfg_data;
                CFG_RUN_ROWS:   r_run_rows   <= i_cfg_data;
                CFG_HSCALE_ON:  r_hscale_on  <= i_cfg_data[0];
                CFG_VSCALE_ON:  r_vscale_on  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Upscale requests clamp to a zero difference
    assign w_hdiff = (r_dst_height > r_src_height) ? '0 : r_src_height - r_dst_height;
    assign w_wdiff = (r_dst_width > r_src_width) ? '0 : r_src_width - r_dst_width;
    assign w_wdiff2     = {w_wdiff, 1'b0};
    assign w_src_width2 = {r_src_width, 1'b0};
    assign w_items_per_row  = (r_run_width[DIM_W-1:1] == '0) ? (DIM_W-1)'(1)
                                                              : r_run_width[DIM_W-1:1];
    assign w_rows_per_frame = (r_run_rows == '0) ? DIM_W'(1) : r_run_rows;

    assign w_col_inc  = {1'b0, r_col_count} + DIM_W'(1);
    assign w_row_inc  = {1'b0, r_row_count} + (DIM_W+1)'(1);
    assign w_last     = (w_col_inc >= {1'b0, w_items_per_row});
    assign w_row_wrap = (w_row_inc >= {1'b0, w_rows_per_frame});

    assign w_first_col   = (r_col_count == '0);
    assign w_frame_first = w_first_col && (r_row_count == '0);

    always_comb begin
        w_ra = w_frame_first ? ACC_W'(w_hdiff) : r_row_accum;
        w_rm = w_frame_first ? '0 : r_row_mark;
        w_rm_lim = {1'b0, w_rm} + (ACC_W+1)'(r_src_height);
        w_row_drop = r_vscale_on && (w_rm <= w_ra) && ({1'b0, w_ra} < w_rm_lim);

        // Row decision and column reload happen on the first item of a row
        if (w_first_col) begin
            w_rd       = w_row_drop;
            n_row_mark = w_row_drop ? w_rm_lim[ACC_W-1:0] : w_rm;
            w_ca       = ACC_W'(w_wdiff2);
            w_cm       = '0;
        end else begin
            w_rd       = r_row_dropping;
            n_row_mark = w_rm;
            w_ca       = r_col_accum;
            w_cm       = r_col_mark;
        end

        w_cm_lim = {1'b0, w_cm} + (ACC_W+1)'(w_src_width2);
        w_drop_h = !w_rd && r_hscale_on && !w_last && (w_cm <= w_ca)
                   && ({1'b0, w_ca} < w_cm_lim);

        n_col_mark     = w_drop_h ? w_cm_lim[ACC_W-1:0] : w_cm;
        n_col_accum    = w_ca + ACC_W'(w_wdiff2);
        n_row_dropping = w_rd;
        n_row_accum    = w_ra;
        n_row_count    = r_row_count;
        n_col_count    = w_col_inc[DIM_W-2:0];

        if (w_last) begin
            n_col_count = '0;
            n_row_accum = w_ra + ACC_W'(w_hdiff);
            n_row_count = w_row_inc[DIM_W-1:0];
            // Frame end: restore start values
            if (w_row_wrap) begin
                n_row_count    = '0;
                n_row_accum    = ACC_W'(w_hdiff);
                n_row_mark     = '0;
                n_col_accum    = ACC_W'(w_wdiff2);
                n_col_mark     = '0;
                n_row_dropping = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= '0;
            r_col_count    <= '0;
            r_row_accum    <= '0;
            r_row_mark     <= '0;
            r_col_accum    <= '0;
            r_col_mark     <= '0;
            r_row_dropping <= 1'b0;
        end else if (i_accept) begin
            r_row_count    <= n_row_count;
            r_col_count    <= n_col_count;
            r_row_accum    <= n_row_accum;
            r_row_mark     <= n_row_mark;
            r_col_accum    <= n_col_accum;
            r_col_mark     <= n_col_mark;
            r_row_dropping <= n_row_dropping;
        end
    end

    assign o_keep          = !w_rd && !w_drop_h;
    assign o_entry.item    = i_item;
    assign o_entry.row_end = w_last;

endmodule
`default_nettype wire

// ===== hdl/ypk_back.sv =====
// YUY2 packing and the result register.
`default_nettype none
module ypk_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ypk_pkg::t_fifo_status i_status,
    input  ypk_pkg::t_entry       i_entry,
    output logic                  o_fifo_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output ypk_pkg::t_out_item    o_item
);
    import ypk_pkg::*;

    logic      r_valid;
    t_out_item r_out;
    t_out_item n_out;
    logic      w_load;

    // Refill the result register when it is free or being taken
    assign w_load = !i_status.empty && (!r_valid || i_pop);

    assign n_out.packed_word = {i_entry.item.chroma_red, i_entry.item.luma_right,
                                i_entry.item.chroma_blue, i_entry.item.luma_left};
    assign n_out.row_end     = i_entry.row_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_fifo_pop = w_load;
    assign o_empty    = !r_valid;
    assign o_item     = r_out;

endmodule
`default_nettype wire

// ===== bench/planar_yuv_to_packed_decimating_packer_tb.sv =====
// Self-checking testbench for the planar YUV to packed YUY2 decimating packer.
`default_nettype none
module planar_yuv_to_packed_decimating_packer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ypk_pkg::*;

    typedef struct {
        bit               is_reg;
        t_cfg_index       reg_idx;
        logic [DIM_W-1:0] reg_val;
        t_in_item         px;
        bit               known;
        t_out_item        want;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_push;
    logic                 o_full;
    t_in_item             i_item;
    logic                 o_empty;
    logic                 i_pop;
    t_out_item            o_item;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    // Register shadow and frame state of the packer prediction
    logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h, run_w, run_r;
    logic             hscale_en, vscale_en;
    logic [11:0]      row_count, col_count;
    logic [ACC_W-1:0] row_accum, row_mark, col_accum, col_mark;
    logic             row_dropping;

    t_out_item   pending_words[$];
    t_stim_row   directed_rows[$];
    bit          gaps_on = 1'b1;
    int unsigned items_sent = 0;
    int unsigned mismatches = 0;

    planar_yuv_to_packed_decimating_packer u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_item      (o_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [DIM_W-1:0] height_excess();
        return (dst_h > src_h) ? '0 : src_h - dst_h;
    endfunction

    // Twice the width difference; an upscale request counts as no difference
    function automatic logic [DIM_W:0] col_stride();
        return (dst_w > src_w) ? '0 : {src_w - dst_w, 1'b0};
    endfunction

    function automatic void restart_frame();
        row_count    = '0;
        col_count    = '0;
        row_accum    = ACC_W'(height_excess());
        row_mark     = '0;
        col_accum    = ACC_W'(col_stride());
        col_mark     = '0;
        row_dropping = 1'b0;
    endfunction

    function automatic void pack_and_decimate(input t_in_item px, output bit kept,
                                              output t_out_item word);
        int unsigned pairs;
        int unsigned frame_rows;
        bit          row_last;
        bit          drop_px;
        pairs = 32'(run_w) >> 1;
        if (pairs == 0) pairs = 1;
        frame_rows = (run_r == '0) ? 1 : 32'(run_r);
        row_last = (32'(col_count) + 1) >= pairs;
        kept = 1'b0;
        word = '0;
        if (col_count == '0) begin
            if (row_count == '0) begin
                row_accum = ACC_W'(height_excess());
                row_mark  = '0;
            end
            // window test on the unwrapped sum
            row_dropping = vscale_en && row_mark <= row_accum &&
                           32'(row_accum) < 32'(row_mark) + 32'(src_h);
            if (row_dropping) row_mark = row_mark + ACC_W'(src_h);
            col_accum = ACC_W'(col_stride());
            col_mark  = '0;
        end
        if (!row_dropping) begin
            drop_px = hscale_en && !row_last && col_mark <= col_accum &&
                      32'(col_accum) < 32'(col_mark) + 2 * 32'(src_w);
            if (drop_px) begin
                col_mark = col_mark + ACC_W'({src_w, 1'b0});
            end else begin
                kept = 1'b1;
                word.packed_word = {px.chroma_red, px.luma_right, px.chroma_blue,
                                    px.luma_left};
                word.row_end = row_last;
            end
        end
        col_accum = col_accum + ACC_W'(col_stride());
        if (row_last) begin
            col_count = '0;
            row_accum = row_accum + ACC_W'(height_excess());
            row_count = row_count + 1'b1;
            if (32'(row_count) >= frame_rows) restart_frame();
        end else begin
            col_count = col_count + 1'b1;
        end
    endfunction

    function automatic t_stim_row reg_row(input t_cfg_index idx, input logic [DIM_W-1:0] val);
        t_stim_row r;
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        r.px      = '0;
        r.known   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic t_stim_row px_row(input t_in_item px, input bit known = 1'b0,
                                         input t_out_item want = '0);
        t_stim_row r;
        r.is_reg  = 1'b0;
        r.reg_idx = CFG_SRC_WIDTH;
        r.reg_val = '0;
        r.px      = px;
        r.known   = known;
        r.want    = want;
        return r;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic send_item(input t_in_item px, input bit known, input t_out_item want);
        bit        kept;
        t_out_item word;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_push <= 1'b1;
        i_item <= px;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        pack_and_decimate(px, kept, word);
        items_sent++;
        @(negedge i_clk);
        // queue on the falling edge so the checker never races the update
        if (known) pending_words.push_back(want);
        else if (kept) pending_words.push_back(word);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [DIM_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SRC_WIDTH:  src_w = val;
            CFG_SRC_HEIGHT: src_h = val;
            CFG_DST_WIDTH:  dst_w = val;
            CFG_DST_HEIGHT: dst_h = val;
            CFG_RUN_WIDTH:  run_w = val;
            CFG_RUN_ROWS:   run_r = val;
            CFG_HSCALE_ON:  hscale_en = val[0];
            CFG_VSCALE_ON:  vscale_en = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain_outstanding();
        i_push <= 1'b0;
        while (pending_words.size() != 0) @(negedge i_clk);
        // dropped macropixels leave nothing to wait on; cover the pipeline depth
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && i_pop && !o_empty) begin
            if (pending_words.size() == 0) begin
                flag_mismatch($sformatf("unexpected word %h row_end %b",
                                        o_item.packed_word, o_item.row_end));
            end else begin
                want = pending_words.pop_front();
                if (o_item.packed_word !== want.packed_word)
                    flag_mismatch($sformatf("packed_word %h, want %h",
                                            o_item.packed_word, want.packed_word));
                if (o_item.row_end !== want.row_end)
                    flag_mismatch($sformatf("row_end %b, want %b (word %h)",
                                            o_item.row_end, want.row_end, want.packed_word));
            end
        end
    end

    initial begin : pop_driver
        int hold;
        hold  = 0;
        i_pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(0, 2);
                i_pop <= 1'b0;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        t_in_item         px;
        logic [DIM_W-1:0] plan [8];
        int unsigned      burst;
        i_rst_n     = 1'b0;
        i_push      = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SRC_WIDTH;
        i_cfg_data  = '0;
        src_w = DIM_RESET;
        src_h = DIM_RESET;
        dst_w = DIM_RESET;
        dst_h = DIM_RESET;
        run_w = DIM_RESET;
        run_r = DIM_RESET;
        hscale_en = 1'b0;
        vscale_en = 1'b0;
        restart_frame();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        directed_rows = '{
            px_row(32'h0000_0000, 1'b1, {32'h0000_0000, 1'b0}),
            px_row(32'hFFFF_FFFF, 1'b1, {32'hFFFF_FFFF, 1'b0}),
            px_row(32'h1234_5678, 1'b1, {32'h7834_5612, 1'b0}),
            px_row(32'hA55A_C33C, 1'b1, {32'h3C5A_C3A5, 1'b0}),
            // row already past the new length: it ends on the next macropixel
            reg_row(CFG_RUN_WIDTH, 12'd4),
            reg_row(CFG_RUN_ROWS, 12'd0),
            px_row(32'h0102_0304),
            px_row(32'h8080_8080),
            px_row(32'h7F7F_7F7F),
            reg_row(CFG_SRC_WIDTH, 12'd8),
            reg_row(CFG_SRC_HEIGHT, 12'd4),
            reg_row(CFG_DST_WIDTH, 12'd4),
            reg_row(CFG_DST_HEIGHT, 12'd3),
            reg_row(CFG_RUN_WIDTH, 12'd8),
            reg_row(CFG_RUN_ROWS, 12'd2),
            reg_row(CFG_HSCALE_ON, 12'd1),
            reg_row(CFG_VSCALE_ON, 12'd1),
            px_row(32'h1020_3040), px_row(32'h1121_3141),
            px_row(32'h1222_3242), px_row(32'h1323_3343),
            px_row(32'h1424_3444), px_row(32'h1525_3545),
            px_row(32'h1626_3646), px_row(32'h1727_3747),
            // target larger than source, and a single macropixel per row
            reg_row(CFG_DST_WIDTH, 12'd4095),
            reg_row(CFG_DST_HEIGHT, 12'd2048),
            reg_row(CFG_RUN_WIDTH, 12'd1),
            reg_row(CFG_RUN_ROWS, 12'd3),
            px_row(32'hC0C1_C2C3), px_row(32'hD0D1_D2D3), px_row(32'hE0E1_E2E3),
            reg_row(CFG_SRC_WIDTH, 12'd2),
            reg_row(CFG_DST_WIDTH, 12'd2),
            reg_row(CFG_RUN_WIDTH, 12'd5),
            reg_row(CFG_VSCALE_ON, 12'd0),
            reg_row(CFG_SRC_HEIGHT, 12'd2048),
            reg_row(CFG_DST_HEIGHT, 12'd1),
            px_row(32'h5566_7788), px_row(32'h99AA_BBCC),
            px_row(32'hDDEE_FF00), px_row(32'h0F1E_2D3C)
        };

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_reg) begin
                if (k == 0 || !directed_rows[k-1].is_reg) drain_outstanding();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
                if (k + 1 == directed_rows.size() || !directed_rows[k+1].is_reg)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_item(directed_rows[k].px, directed_rows[k].known, directed_rows[k].want);
            end
        end

        while (items_sent < 650) begin
            drain_outstanding();
            gaps_on = (items_sent < 550) && ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 15))
                0:       plan[CFG_SRC_WIDTH] = 12'd2;
                1:       plan[CFG_SRC_WIDTH] = 12'd2048;
                2:       plan[CFG_SRC_WIDTH] = 12'($urandom);
                default: plan[CFG_SRC_WIDTH] = 12'($urandom_range(1, 16) * 2);
            endcase
            case ($urandom_range(0, 15))
                0:       plan[CFG_DST_WIDTH] = plan[CFG_SRC_WIDTH];
                1:       plan[CFG_DST_WIDTH] = 12'd2;
                2:       plan[CFG_DST_WIDTH] = 12'($urandom);
                3:       plan[CFG_DST_WIDTH] = plan[CFG_SRC_WIDTH] + 12'd2;
                default: plan[CFG_DST_WIDTH] =
                             12'($urandom_range(1, plan[CFG_SRC_WIDTH])) & 12'hFFE;
            endcase
            case ($urandom_range(0, 15))
                0:       plan[CFG_SRC_HEIGHT] = 12'd1;
                1:       plan[CFG_SRC_HEIGHT] = 12'd2048;
                2:       plan[CFG_SRC_HEIGHT] = 12'($urandom);
                default: plan[CFG_SRC_HEIGHT] = 12'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 15))
                0:       plan[CFG_DST_HEIGHT] = plan[CFG_SRC_HEIGHT];
                1:       plan[CFG_DST_HEIGHT] = 12'd1;
                2:       plan[CFG_DST_HEIGHT] = 12'($urandom);
                3:       plan[CFG_DST_HEIGHT] = plan[CFG_SRC_HEIGHT] + 12'd1;
                default: plan[CFG_DST_HEIGHT] = 12'($urandom_range(1, plan[CFG_SRC_HEIGHT]));
            endcase
            case ($urandom_range(0, 31))
                0:       plan[CFG_RUN_WIDTH] = 12'd0;
                1:       plan[CFG_RUN_WIDTH] = 12'd1;
                2, 3:    plan[CFG_RUN_WIDTH] = 12'($urandom_range(1, 6) * 2 + 1);
                4:       plan[CFG_RUN_WIDTH] = 12'd2048;
                5:       plan[CFG_RUN_WIDTH] = 12'($urandom);
                default: plan[CFG_RUN_WIDTH] = 12'($urandom_range(1, 6) * 2);
            endcase
            case ($urandom_range(0, 15))
                0:       plan[CFG_RUN_ROWS] = 12'd0;
                1:       plan[CFG_RUN_ROWS] = 12'd2048;
                2:       plan[CFG_RUN_ROWS] = 12'($urandom);
                default: plan[CFG_RUN_ROWS] = 12'($urandom_range(1, 6));
            endcase
            // upper bits of the enables are don't-care; drive them anyway
            plan[CFG_HSCALE_ON] = 12'($urandom);
            plan[CFG_VSCALE_ON] = 12'($urandom);

            for (int r = 0; r < 8; r++) write_reg(t_cfg_index'(r), plan[r]);
            i_cfg_valid <= 1'b0;

            burst = $urandom_range(10, 70);
            repeat (burst) begin
                px = t_in_item'($urandom);
                case ($urandom_range(0, 7))
                    0:       px = '0;
                    1:       px = '1;
                    default: ;
                endcase
                send_item(px, 1'b0, '0);
            end
        end

        gaps_on = 1'b0;
        drain_outstanding();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : watchdog
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire
